@@ sv/brk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brk_pkg: shared types and codes for the breakout trigger
// Bar and event payload structs, event kinds, register indexes, unit control.
// ----------------------------------------------------------------------------
package brk_pkg;

	localparam int MULT_W = 10;   // widest volatility multiple
	localparam int HELD_W = 11;

	// event kinds
	localparam logic [1:0] EV_ENTRY  = 2'd0;
	localparam logic [1:0] EV_STOP   = 2'd1;
	localparam logic [1:0] EV_TARGET = 2'd2;
	localparam logic [1:0] EV_TIME   = 2'd3;

	// register indexes
	localparam logic [1:0] REG_LOOKBACK = 2'd0;
	localparam logic [1:0] REG_HOLD     = 2'd1;
	localparam logic [1:0] REG_STOP     = 2'd2;
	localparam logic [1:0] REG_TARGET   = 2'd3;

	typedef struct packed {
		logic        is_hourly;
		logic [31:0] bar_close;
		logic [31:0] bar_high;
		logic [31:0] bar_low;
		logic [31:0] atr_value;
		logic        atr_valid;
		logic [63:0] bar_time;
	} bar_item_t;

	typedef struct packed {
		logic [1:0]        event_kind;
		logic [HELD_W-1:0] bars_held;
		logic [63:0]       event_time;
	} evt_item_t;

	// control of the shared multiply / level unit
	typedef struct packed {
		logic              mul_go;
		logic [MULT_W-1:0] multiple;
		logic              sel_target;
	} alu_ctl_t;

endpackage

@@ sv/brk_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brk_ring: ring memory of past bar highs
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module brk_ring #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ sv/brk_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brk_alu: shared multiply and level unit
// Registers multiple * volatility, then forms a stop or a target level.
// ----------------------------------------------------------------------------
module brk_alu #(
	parameter int PRICE_BITS = 32
) (
	input  logic                  clk,
	input  brk_pkg::alu_ctl_t     ctl,
	input  logic [PRICE_BITS-1:0] atr,
	input  logic [PRICE_BITS-1:0] close_px,
	output logic [PRICE_BITS-1:0] level
);
	import brk_pkg::*;

	localparam int PROD_W = PRICE_BITS + MULT_W;
	localparam int DIST_W = PROD_W - 4;
	localparam int SUM_W  = DIST_W + 1;

	logic [PROD_W-1:0] prod_q;
	logic              nz_q;
	logic [PROD_W-1:0] prod_rnd;
	logic [DIST_W-1:0] dist_c;
	logic [SUM_W-1:0]  sum;

	always_ff @(posedge clk) begin
		if (ctl.mul_go) begin
			prod_q <= PROD_W'(ctl.multiple) * PROD_W'(atr);
			nz_q   <= (ctl.multiple != '0);
		end
	end

	// distance = ceil(product / 16)
	assign prod_rnd = prod_q + PROD_W'(15);
	assign dist_c   = prod_rnd[PROD_W-1:4];
	assign sum      = SUM_W'(close_px) + SUM_W'(dist_c);

	always_comb begin
		level = '0;
		if (nz_q) begin
			if (ctl.sel_target) begin
				if (sum[SUM_W-1:PRICE_BITS] != '0) begin
					level = '1;
				end else begin
					level = sum[PRICE_BITS-1:0];
				end
			end else if (dist_c < DIST_W'(close_px)) begin
				level = close_px - dist_c[PRICE_BITS-1:0];
			end
		end
	end

endmodule

@@ sv/breakout_trigger_with_exits_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breakout_trigger_with_exits_top: channel breakout entry with stop,
// target and time exits
// Scans the ring of past highs on a flat bar; arms levels on entry.
// ----------------------------------------------------------------------------
// Usage:
//   Bars arrive on the bar channel (bar_valid / bar_ready / bar). Each
//   accepted transfer yields zero or one event on the evt channel
//   (evt_valid / evt_ready / evt): an entry, or a stop, target or time exit.
//   Registers sit on the APB port at byte addresses 0, 4, 8 and 12 and
//   must be written only while the block is idle; the block itself does
//   not enforce this. A bar that is not hourly is decided and dropped. A
//   bar while holding, or a flat bar before the window fills, is decided,
//   pushed, and loaded into the output register when it makes an event. A
//   flat bar with a full window is first scanned over n stored highs, n
//   being the clamped lookback (up to WINDOW_DEPTH - 1): the scan reads one
//   stored high per cycle through the ring's single read port and folds it
//   into a running maximum. An entry then passes S_MULS, S_MULT and S_LVLT
//   on the shared multiplier for both levels, then is pushed and loaded out.
//   The event sits in an output register; a stalled receiver holds it
//   there, and a following bar that makes an event waits until it drains.
//   Reset empties the window, goes flat, disarms both levels and loads
//   the register defaults (lookback 168, hold 72, multiples 0).
// ----------------------------------------------------------------------------
module breakout_trigger_with_exits_top #(
	parameter int WINDOW_DEPTH = 512,
	parameter int PRICE_BITS   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	// bar channel
	input  logic                bar_valid,
	output logic                bar_ready,
	input  brk_pkg::bar_item_t  bar,
	// event channel
	output logic                evt_valid,
	input  logic                evt_ready,
	output brk_pkg::evt_item_t  evt,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import brk_pkg::*;

	localparam int AW    = $clog2(WINDOW_DEPTH);
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int NMAX  = WINDOW_DEPTH - 1;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECIDE = 8'b0000_0010,
		S_SCAN   = 8'b0000_0100,
		S_MULS   = 8'b0000_1000,
		S_MULT   = 8'b0001_0000,
		S_LVLT   = 8'b0010_0000,
		S_PUSH   = 8'b0100_0000,
		S_OUT    = 8'b1000_0000
	} state_t;

	state_t state_q;

	// registers
	logic [8:0]        lookback_q;
	logic [10:0]       hold_q;
	logic [8:0]        stop_mult_q;
	logic [9:0]        tgt_mult_q;

	// captured bar
	logic                  hourly_q;
	logic [PRICE_BITS-1:0] close_q;
	logic [PRICE_BITS-1:0] high_q;
	logic [PRICE_BITS-1:0] low_q;
	logic [PRICE_BITS-1:0] atr_q;
	logic                  atr_ok_q;
	logic [63:0]           time_q;

	// trade and window state
	logic                  holding_q;
	logic [HELD_W-1:0]     held_q;
	logic [PRICE_BITS-1:0] stop_q;
	logic [PRICE_BITS-1:0] tgt_q;
	logic [AW-1:0]         slot_q;
	logic [CNT_W-1:0]      fill_q;

	// scan
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      issue_q;
	logic [AW-1:0]         rd_ptr_q;
	logic                  rd_vld_s1;
	logic [PRICE_BITS-1:0] max_q;

	// pending result
	logic              res_q;
	logic [1:0]        res_kind_q;
	logic [HELD_W-1:0] res_held_q;

	logic      evt_valid_q;
	evt_item_t evt_q;

	logic                  cfg_wr;
	logic [CNT_W-1:0]      n_c;
	logic [HELD_W-1:0]     held_inc;
	logic [10:0]           limit_c;
	logic                  stop_hit, tgt_hit, time_hit;
	logic                  rd_en;
	logic [PRICE_BITS-1:0] rd_data;
	logic [PRICE_BITS-1:0] max_nx;
	logic                  scan_done;
	alu_ctl_t              alu_ctl;
	logic [PRICE_BITS-1:0] alu_level;
	logic                  atr_usable;

	function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
		return (p == '0) ? AW'(WINDOW_DEPTH - 1) : p - AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(WINDOW_DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookback_q  <= 9'd168;
			hold_q      <= 11'd72;
			stop_mult_q <= '0;
			tgt_mult_q  <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_LOOKBACK: lookback_q  <= pwdata[8:0];
				REG_HOLD:     hold_q      <= pwdata[10:0];
				REG_STOP:     stop_mult_q <= pwdata[8:0];
				REG_TARGET:   tgt_mult_q  <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_LOOKBACK: prdata = 32'(lookback_q);
			REG_HOLD:     prdata = 32'(hold_q);
			REG_STOP:     prdata = 32'(stop_mult_q);
			REG_TARGET:   prdata = 32'(tgt_mult_q);
			default:      prdata = '0;
		endcase
	end

	// ------------------------------------------------------ decision logic
	// Clamp the lookback into 1 .. WINDOW_DEPTH-1.
	always_comb begin
		if (lookback_q == '0) begin
			n_c = CNT_W'(1);
		end else if (lookback_q >= NMAX) begin
			n_c = CNT_W'(NMAX);
		end else begin
			n_c = CNT_W'(lookback_q);
		end
	end

	// Saturate the held count; a zero hold acts as one.
	assign held_inc = (held_q != '1) ? held_q + HELD_W'(1) : held_q;
	assign limit_c  = (hold_q == '0) ? 11'd1 : hold_q;
	assign stop_hit = (stop_q != '0) && (low_q <= stop_q);
	assign tgt_hit  = (tgt_q != '0) && (high_q >= tgt_q);
	assign time_hit = (held_inc >= limit_c);

	// Issue one ring read per cycle, fold returning data into the maximum.
	assign rd_en     = (state_q == S_SCAN) && (issue_q != n_q);
	assign max_nx    = (rd_vld_s1 && (rd_data > max_q)) ? rd_data : max_q;
	assign scan_done = (issue_q == n_q) && rd_vld_s1;

	assign atr_usable = atr_ok_q && (atr_q != '0);

	always_comb begin
		alu_ctl = '0;
		unique case (state_q)
			S_MULS: begin
				alu_ctl.mul_go   = 1'b1;
				alu_ctl.multiple = MULT_W'(stop_mult_q);
			end
			S_MULT: begin
				alu_ctl.mul_go   = 1'b1;
				alu_ctl.multiple = tgt_mult_q;
			end
			S_LVLT: begin
				alu_ctl.sel_target = 1'b1;
			end
			default: ;
		endcase
	end

	brk_ring #(
		.DEPTH (WINDOW_DEPTH),
		.WIDTH (PRICE_BITS)
	) u_ring (
		.clk     (clk),
		.wr_en   (state_q == S_PUSH),
		.wr_addr (slot_q),
		.wr_data (high_q),
		.rd_en   (rd_en),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data)
	);

	brk_alu #(
		.PRICE_BITS (PRICE_BITS)
	) u_alu (
		.clk      (clk),
		.ctl      (alu_ctl),
		.atr      (atr_q),
		.close_px (close_q),
		.level    (alu_level)
	);

	// -------------------------------------------------------- sequencer
	assign bar_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			holding_q   <= 1'b0;
			held_q      <= '0;
			stop_q      <= '0;
			tgt_q       <= '0;
			slot_q      <= '0;
			fill_q      <= '0;
			issue_q     <= '0;
			rd_vld_s1   <= 1'b0;
			res_q       <= 1'b0;
			evt_valid_q <= 1'b0;
		end else begin
			// load the output register when the event is ready, else drain it
			if ((state_q == S_OUT) && (!evt_valid_q || evt_ready)) begin
				evt_valid_q <= 1'b1;
			end else if (evt_valid_q && evt_ready) begin
				evt_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (bar_valid) begin
						state_q <= S_DECIDE;
					end
				end

				S_DECIDE: begin
					res_q <= hourly_q && holding_q && (stop_hit || tgt_hit || time_hit);
					if (!hourly_q) begin
						// ignored bar: no event, no push
						state_q <= S_IDLE;
					end else if (holding_q) begin
						state_q <= S_PUSH;
						if (stop_hit || tgt_hit || time_hit) begin
							res_held_q <= held_inc;
							if (stop_hit) begin
								res_kind_q <= EV_STOP;
							end else if (tgt_hit) begin
								res_kind_q <= EV_TARGET;
							end else begin
								res_kind_q <= EV_TIME;
							end
							holding_q <= 1'b0;
							held_q    <= '0;
							stop_q    <= '0;
							tgt_q     <= '0;
						end else begin
							held_q <= held_inc;
						end
					end else if (fill_q >= n_c) begin
						state_q   <= S_SCAN;
						n_q       <= n_c;
						issue_q   <= '0;
						rd_ptr_q  <= ptr_prev(slot_q);
						rd_vld_s1 <= 1'b0;
						max_q     <= '0;
					end else begin
						state_q <= S_PUSH;
					end
				end

				S_SCAN: begin
					// no read is issued on the last cycle, so the flag clears itself
					rd_vld_s1 <= rd_en;
					if (rd_en) begin
						rd_ptr_q <= ptr_prev(rd_ptr_q);
						issue_q  <= issue_q + CNT_W'(1);
					end
					if (rd_vld_s1) begin
						max_q <= max_nx;
					end
					if (scan_done) begin
						if (close_q > max_nx) begin
							res_q      <= 1'b1;
							res_kind_q <= EV_ENTRY;
							res_held_q <= '0;
							holding_q  <= 1'b1;
							held_q     <= '0;
							state_q    <= S_MULS;
						end else begin
							state_q <= S_PUSH;
						end
					end
				end

				S_MULS: begin
					state_q <= S_MULT;
				end

				S_MULT: begin
					// product register holds the stop product here
					stop_q  <= atr_usable ? alu_level : '0;
					state_q <= S_LVLT;
				end

				S_LVLT: begin
					tgt_q   <= atr_usable ? alu_level : '0;
					state_q <= S_PUSH;
				end

				S_PUSH: begin
					slot_q <= ptr_next(slot_q);
					if (fill_q != CNT_W'(WINDOW_DEPTH)) begin
						fill_q <= fill_q + CNT_W'(1);
					end
					state_q <= res_q ? S_OUT : S_IDLE;
				end

				S_OUT: begin
					// wait until the output register is free
					if (!evt_valid_q || evt_ready) begin
						state_q <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (bar_valid && bar_ready) begin
			hourly_q <= bar.is_hourly;
			close_q  <= PRICE_BITS'(bar.bar_close);
			high_q   <= PRICE_BITS'(bar.bar_high);
			low_q    <= PRICE_BITS'(bar.bar_low);
			atr_q    <= PRICE_BITS'(bar.atr_value);
			atr_ok_q <= bar.atr_valid;
			time_q   <= bar.bar_time;
		end
		if ((state_q == S_OUT) && (!evt_valid_q || evt_ready)) begin
			evt_q.event_kind <= res_kind_q;
			evt_q.bars_held  <= res_held_q;
			evt_q.event_time <= time_q;
		end
	end

	assign evt_valid = evt_valid_q;
	assign evt       = evt_q;

endmodule

@@ sv/brk_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brk_chk: port checker for the breakout trigger
// Watches the bar and event channels; bound to the top level.
// ----------------------------------------------------------------------------
module brk_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               bar_valid,
	input logic               bar_ready,
	input logic               evt_valid,
	input logic               evt_ready,
	input brk_pkg::evt_item_t evt
);
	import brk_pkg::*;

	// a stalled event holds its payload
	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid && $stable(evt))
		else $error("event changed while stalled");

	// one bar at a time: busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		bar_valid && bar_ready |=> !bar_ready)
		else $error("bar accepted back to back");

	// entries report no held bars
	a_entry_held: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && (evt.event_kind == EV_ENTRY) |-> evt.bars_held == '0)
		else $error("entry with nonzero held count");

	// exits always report at least one held bar
	a_exit_held: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && (evt.event_kind != EV_ENTRY) |-> evt.bars_held != '0)
		else $error("exit with zero held count");

endmodule

bind breakout_trigger_with_exits_top brk_chk u_brk_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.bar_valid (bar_valid),
	.bar_ready (bar_ready),
	.evt_valid (evt_valid),
	.evt_ready (evt_ready),
	.evt       (evt)
);
